### rtl/core/ternary_register_machine_top_defines.svh
// Assertion macros shared by the ternary register machine RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef TERNARY_REGISTER_MACHINE_TOP_DEFINES_SVH
`define TERNARY_REGISTER_MACHINE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge while reset is released.
`define TRM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, also during reset.
`define TRM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TRM_ASSERT(label, clk, rst_n, prop, msg)
`define TRM_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### rtl/core/trm_pkg.sv
`default_nettype none

package trm_pkg;

    localparam int NUM_REGS_DEF = 256;

    localparam logic [8:0] REGS_IN_USE_RESET = 9'd256;

    // Largest legal trit value; a SET above it is rejected.
    localparam logic [1:0] TRIT_MAX = 2'd2;

    localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;

    // The 64-bit FNV prime is 2^40 + 0x1B3.
    localparam int         FNV_PRIME_SHIFT = 40;
    localparam logic [8:0] FNV_PRIME_LOW   = 9'h1B3;

    typedef enum logic [2:0] {
        OP_SET,
        OP_ROT,
        OP_ADD,
        OP_MAC,
        OP_SWAP,
        OP_CXCHG,
        OP_READ,
        OP_DIGEST
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_ALIAS,
        ST_BADSET
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RA,
        S_RB,
        S_RT,
        S_EXEC,
        S_WR2,
        S_DIG,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        op_t        op;
        status_t    status;
        logic [7:0] reg_a;
        logic [7:0] reg_b;
        logic [7:0] reg_target;
        logic [1:0] rot_trit;
        logic [1:0] load_value;
    } trm_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  read_value;
        logic [63:0] digest_hash;
        logic [8:0]  nonzero_count;
    } trm_res_t;

    function automatic logic [1:0] add3(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    function automatic logic [1:0] mul3(input logic [1:0] a, input logic [1:0] b);
        logic [3:0] p;
        p = {2'b00, a} * {2'b00, b};
        return (p >= 4'd3) ? 2'(p - 4'd3) : p[1:0];
    endfunction

    // Signed 32-bit amount reduced modulo 3. Hex digits are summed since
    // 16 is 1 modulo 3, and 2^32 is 1 modulo 3, so a negative value adds 2.
    function automatic logic [1:0] rot_mod3(input logic signed [31:0] amount);
        logic [6:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        logic [1:0] r;
        s1 = '0;
        for (int i = 0; i < 8; i++)
        begin
            s1 = s1 + 7'(amount[4*i +: 4]);
        end
        s2 = 4'(s1[6]) + 4'(s1[5:4]) + 4'(s1[3:2]) + 4'(s1[1:0]);
        s3 = 3'(s2[3:2]) + 3'(s2[1:0]);
        r  = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
        return amount[31] ? add3(r, TRIT_MAX) : r;
    endfunction

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [1:0] v);
        logic [63:0] x;
        x = h ^ {62'd0, v};
        return (x << FNV_PRIME_SHIFT) + 64'(x * FNV_PRIME_LOW);
    endfunction

    function automatic status_t check_status(
        input op_t        op,
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] t,
        input logic [1:0] lv,
        input logic [8:0] used
    );
        logic    ia;
        logic    ib;
        logic    it;
        status_t st;
        ia = {1'b0, a} < used;
        ib = {1'b0, b} < used;
        it = {1'b0, t} < used;
        st = ST_OK;
        unique case (op)
            OP_SET:
            begin
                priority if (!it)
                    st = ST_RANGE;
                else if (lv > TRIT_MAX)
                    st = ST_BADSET;
            end
            OP_ROT, OP_READ:
            begin
                if (!it)
                    st = ST_RANGE;
            end
            OP_ADD:
            begin
                priority if (!ia || !it)
                    st = ST_RANGE;
                else if (a == t)
                    st = ST_ALIAS;
            end
            OP_MAC:
            begin
                priority if (!ia || !ib || !it)
                    st = ST_RANGE;
                else if (a == t || b == t)
                    st = ST_ALIAS;
            end
            OP_SWAP:
            begin
                priority if (!ia || !ib)
                    st = ST_RANGE;
                else if (a == b)
                    st = ST_ALIAS;
            end
            OP_CXCHG:
            begin
                priority if (!ia || !ib || !it)
                    st = ST_RANGE;
                else if (a == b || t == a || t == b)
                    st = ST_ALIAS;
            end
            OP_DIGEST:
            begin
                st = ST_OK;
            end
        endcase
        return st;
    endfunction

endpackage

`default_nettype wire

### rtl/core/trm_channels.sv
`default_nettype none

interface trm_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [7:0]         reg_a;
    logic [7:0]         reg_b;
    logic [7:0]         reg_target;
    logic signed [31:0] amount;
    logic [1:0]         load_value;

    modport source (
        output valid, op, reg_a, reg_b, reg_target, amount, load_value,
        input  ready
    );
    modport sink (
        input  valid, op, reg_a, reg_b, reg_target, amount, load_value,
        output ready
    );
endinterface

interface trm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  read_value;
    logic [63:0] digest_hash;
    logic [8:0]  nonzero_count;

    modport source (
        output valid, status, read_value, digest_hash, nonzero_count,
        input  ready
    );
    modport sink (
        input  valid, status, read_value, digest_hash, nonzero_count,
        output ready
    );
endinterface

`default_nettype wire

### rtl/core/trm_core.sv
`default_nettype none
`include "ternary_register_machine_top_defines.svh"

module trm_core #(
    parameter int NUM_REGS = trm_pkg::NUM_REGS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire trm_pkg::trm_cmd_t cmd,
    input  wire logic [8:0]        used_count,
    output logic                   cmd_ready,
    output logic                   res_valid,
    output trm_pkg::trm_res_t      res,
    input  wire logic              res_take
);
    import trm_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    logic [1:0] trit_mem [NUM_REGS];

    seq_state_t  state_reg, state_next;
    trm_cmd_t    cmd_reg, cmd_next;
    logic [1:0]  rd_q_reg;
    logic [1:0]  a_val_reg, a_val_next;
    logic [1:0]  b_val_reg, b_val_next;
    logic [1:0]  rd_val_reg, rd_val_next;
    logic [63:0] hash_reg, hash_next;
    logic [8:0]  nz_reg, nz_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [8:0]  idx_reg, idx_next;
    logic        dv_reg, dv_next;

    logic          we_c;
    logic [AW-1:0] waddr_c;
    logic [AW-1:0] raddr_c;
    logic [1:0]    wdata_c;
    logic          dig_issue;

    // Trit store with one write port and one registered read port: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we_c)
        begin
            trit_mem[waddr_c] <= wdata_c;
        end
        rd_q_reg <= trit_mem[raddr_c];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= '0;
            dv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            dv_reg    <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        a_val_reg  <= a_val_next;
        b_val_reg  <= b_val_next;
        rd_val_reg <= rd_val_next;
        hash_reg   <= hash_next;
        nz_reg     <= nz_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        a_val_next  = a_val_reg;
        b_val_next  = b_val_reg;
        rd_val_next = rd_val_reg;
        hash_next   = hash_reg;
        nz_next     = nz_reg;
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        dv_next     = dv_reg;
        we_c        = 1'b0;
        waddr_c     = AW'(cmd_reg.reg_target);
        wdata_c     = 2'd0;
        raddr_c     = AW'(cmd_reg.reg_target);
        dig_issue   = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                we_c    = 1'b1;
                waddr_c = clr_reg;
                if (clr_reg == AW'(NUM_REGS - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    rd_val_next = 2'd0;
                    hash_next   = 64'd0;
                    nz_next     = 9'd0;
                    idx_next    = 9'd0;
                    dv_next     = 1'b0;
                    if (cmd.status != ST_OK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        unique case (cmd.op)
                            OP_SET:
                                state_next = S_EXEC;
                            OP_ROT, OP_READ:
                                state_next = S_RT;
                            OP_DIGEST:
                            begin
                                hash_next  = FNV_OFFSET;
                                state_next = S_DIG;
                            end
                            OP_ADD, OP_MAC, OP_SWAP, OP_CXCHG:
                                state_next = S_RA;
                        endcase
                    end
                end
            end
            S_RA:
            begin
                raddr_c    = AW'(cmd_reg.reg_a);
                state_next = S_RB;
            end
            S_RB:
            begin
                raddr_c    = AW'(cmd_reg.reg_b);
                a_val_next = rd_q_reg;
                state_next = S_RT;
            end
            S_RT:
            begin
                raddr_c    = AW'(cmd_reg.reg_target);
                b_val_next = rd_q_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // The target value read in the previous state is in rd_q_reg now.
                state_next = S_DONE;
                unique case (cmd_reg.op)
                    OP_SET:
                    begin
                        we_c    = 1'b1;
                        wdata_c = cmd_reg.load_value;
                    end
                    OP_ROT:
                    begin
                        we_c    = 1'b1;
                        wdata_c = add3(rd_q_reg, cmd_reg.rot_trit);
                    end
                    OP_ADD:
                    begin
                        we_c    = 1'b1;
                        wdata_c = add3(rd_q_reg, a_val_reg);
                    end
                    OP_MAC:
                    begin
                        we_c    = 1'b1;
                        wdata_c = add3(rd_q_reg, mul3(a_val_reg, b_val_reg));
                    end
                    OP_SWAP:
                    begin
                        we_c       = 1'b1;
                        waddr_c    = AW'(cmd_reg.reg_a);
                        wdata_c    = b_val_reg;
                        state_next = S_WR2;
                    end
                    OP_CXCHG:
                    begin
                        if (rd_q_reg == 2'd1)
                        begin
                            we_c       = 1'b1;
                            waddr_c    = AW'(cmd_reg.reg_a);
                            wdata_c    = b_val_reg;
                            state_next = S_WR2;
                        end
                    end
                    OP_READ:
                    begin
                        rd_val_next = rd_q_reg;
                    end
                    OP_DIGEST:
                    begin
                        rd_val_next = 2'd0;
                    end
                endcase
            end
            S_WR2:
            begin
                we_c       = 1'b1;
                waddr_c    = AW'(cmd_reg.reg_b);
                wdata_c    = a_val_reg;
                state_next = S_DONE;
            end
            S_DIG:
            begin
                // One read is issued per cycle and folded in the cycle after.
                raddr_c   = AW'(idx_reg);
                dig_issue = idx_reg < used_count;
                if (dv_reg)
                begin
                    hash_next = fnv_step(hash_reg, rd_q_reg);
                    if (rd_q_reg != 2'd0)
                        nz_next = nz_reg + 1'b1;
                end
                dv_next = dig_issue;
                if (dig_issue)
                    idx_next = idx_reg + 1'b1;
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
        endcase
    end

    assign cmd_ready         = (state_reg == S_IDLE);
    assign res_valid         = (state_reg == S_DONE);
    assign res.status        = cmd_reg.status;
    assign res.read_value    = rd_val_reg;
    assign res.digest_hash   = hash_reg;
    assign res.nonzero_count = nz_reg;

    `TRM_ASSERT(a_no_write_when_idle, clk, rst_n, (state_reg == S_IDLE || state_reg == S_DONE) |-> !we_c, "trit store written outside an instruction")
    `TRM_ASSERT(a_second_write_swap, clk, rst_n, (state_reg == S_WR2) |-> (cmd_reg.op == OP_SWAP || cmd_reg.op == OP_CXCHG), "second write for an op that does not exchange")
    `TRM_ASSERT(a_fault_zero_payload, clk, rst_n, (res_valid && res.status != ST_OK) |-> (res.read_value == 2'd0 && res.digest_hash == 64'd0 && res.nonzero_count == 9'd0), "faulting instruction returned data")

endmodule

`default_nettype wire

### rtl/core/ternary_register_machine_top.sv
// Ternary register machine: executes one instruction per input transfer on a
// file of NUM_REGS trit registers and returns one result transfer for each.
// After reset the block clears the trit store, one register per cycle, and
// accepts no instruction meanwhile; configuration writes are taken at any
// time but must only be issued while the block is idle. All registers are held
// in one memory with one write port and one registered read port, so an
// instruction reads and writes its registers in turn: a faulting one goes
// straight to its result, SET writes the target, ROT and READ read the target
// and then write or return it, ADD, MAC, SWAP and CXCHG read reg_a, reg_b and
// the target, then ADD and MAC write the target and SWAP and an exchanging
// CXCHG write reg_a and then reg_b, and DIGEST reads registers_in_use
// registers, capped at NUM_REGS. The result is presented in the same cycle in
// which the next instruction can be accepted, and an output register holds it
// while later work goes on. A finished instruction waits for a free output
// register, so a stalled output stalls the input one instruction later.
`default_nettype none
`include "ternary_register_machine_top_defines.svh"

module ternary_register_machine_top #(
    parameter int NUM_REGS = trm_pkg::NUM_REGS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic [8:0] cfg_write_data,
    trm_in_if.sink          in_ch,
    trm_out_if.source       out_ch
);
    import trm_pkg::*;

    localparam int CW = ($clog2(NUM_REGS + 1) > 9) ? $clog2(NUM_REGS + 1) : 9;

    logic [8:0] regs_in_use_reg;
    logic [8:0] used_count;

    trm_cmd_t core_cmd;
    trm_res_t core_res;
    logic     core_ready;
    logic     core_res_valid;
    logic     res_load;

    logic     out_valid_reg, out_valid_next;
    trm_res_t out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            regs_in_use_reg <= REGS_IN_USE_RESET;
        else if (cfg_write_en)
            regs_in_use_reg <= cfg_write_data;
    end

    // A count beyond the store size addresses the whole store.
    assign used_count = (CW'(regs_in_use_reg) > CW'(NUM_REGS)) ? 9'(NUM_REGS)
                                                                : regs_in_use_reg;

    always_comb
    begin
        core_cmd.op         = op_t'(in_ch.op);
        core_cmd.reg_a      = in_ch.reg_a;
        core_cmd.reg_b      = in_ch.reg_b;
        core_cmd.reg_target = in_ch.reg_target;
        core_cmd.load_value = in_ch.load_value;
        core_cmd.rot_trit   = rot_mod3(in_ch.amount);
        core_cmd.status     = check_status(op_t'(in_ch.op), in_ch.reg_a, in_ch.reg_b,
                                           in_ch.reg_target, in_ch.load_value,
                                           used_count);
    end

    assign in_ch.ready = core_ready;

    trm_core #(
        .NUM_REGS (NUM_REGS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (in_ch.valid),
        .cmd        (core_cmd),
        .used_count (used_count),
        .cmd_ready  (core_ready),
        .res_valid  (core_res_valid),
        .res        (core_res),
        .res_take   (res_load)
    );

    // The output register takes a new result when it is empty or its
    // current transfer completes in this cycle.
    assign res_load = core_res_valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_res_reg <= core_res;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_res_reg.status;
    assign out_ch.read_value    = out_res_reg.read_value;
    assign out_ch.digest_hash   = out_res_reg.digest_hash;
    assign out_ch.nonzero_count = out_res_reg.nonzero_count;

    `TRM_ASSERT(a_out_from_core, clk, rst_n, $rose(out_valid_reg) |-> $past(core_res_valid), "result appeared without a finished instruction")
    `TRM_ASSERT(a_used_capped, clk, rst_n, CW'(used_count) <= CW'(NUM_REGS), "register count exceeds the store")
    `TRM_ASSERT(a_busy_after_accept, clk, rst_n, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "instruction accepted while one is in progress")

endmodule

`default_nettype wire
